// ===== rtl/mbrfb_pkg.sv =====
`timescale 1ns / 1ps
package mbrfb_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam int IN_DATA_W = 48;
	localparam int IN_USER_W = 5;
	localparam int BODY_BYTES = 6;

	localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;

	localparam logic       OP_READ = 1'b0;
	localparam logic       OP_WRITE = 1'b1;

	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_TCP = 2'd1;
	localparam logic [1:0] MODE_CRC = 2'd2;

	localparam logic [1:0] KIND_ANALOG = 2'd0;
	localparam logic [1:0] KIND_DIGITAL = 2'd1;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// byte index of the final result for each frame shape
	localparam logic [3:0] LAST_UNSUP = 4'd0;
	localparam logic [3:0] LAST_PLAIN = 4'd5;
	localparam logic [3:0] LAST_CRC = 4'd7;
	localparam logic [3:0] LAST_TCP = 4'd11;
	localparam logic [3:0] IDX_BODY_END = 4'd6;

	// TCP header, entry 0 goes out first
	localparam logic [5:0][7:0] TCP_HEADER = {8'h06, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00};

	typedef struct packed {
		logic                  unsup;
		logic [1:0]            mode;
		logic [5:0][7:0]       body;
	} frame_desc_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/mbrfb_front.sv =====
`timescale 1ns / 1ps
module mbrfb_front (
	input  logic [mbrfb_pkg::IN_DATA_W-1:0] tdata,
	input  logic [mbrfb_pkg::IN_USER_W-1:0] tuser,
	output mbrfb_pkg::frame_desc_t          desc
);
	import mbrfb_pkg::*;

	logic        op;
	logic [1:0]  frame_mode;
	logic [1:0]  value_kind;
	logic [7:0]  unit_address;
	logic [15:0] register_address;
	logic [7:0]  register_count;
	logic [15:0] write_value;

	assign op = tuser[0];
	assign frame_mode = tuser[2:1];
	assign value_kind = tuser[4:3];
	assign unit_address = tdata[7:0];
	assign register_address = tdata[23:8];
	assign register_count = tdata[31:24];
	assign write_value = tdata[47:32];

	always_comb begin
		desc.unsup = (op == OP_WRITE) && (value_kind != KIND_ANALOG)
			&& (value_kind != KIND_DIGITAL);
		case (frame_mode)
			MODE_TCP: desc.mode = MODE_TCP;
			MODE_CRC: desc.mode = MODE_CRC;
			default:  desc.mode = MODE_PLAIN;
		endcase
		desc.body[0] = unit_address;
		desc.body[1] = (op == OP_READ) ? FUNC_READ_HOLDING : FUNC_WRITE_SINGLE;
		desc.body[2] = register_address[15:8];
		desc.body[3] = register_address[7:0];
		if (op == OP_READ) begin
			desc.body[4] = 8'h00;
			desc.body[5] = register_count;
		end else if (value_kind == KIND_ANALOG) begin
			desc.body[4] = write_value[15:8];
			desc.body[5] = write_value[7:0];
		end else begin
			desc.body[4] = 8'h00;
			desc.body[5] = write_value[7:0];
		end
	end

endmodule

// ===== rtl/mbrfb_queue.sv =====
`timescale 1ns / 1ps
module mbrfb_queue #(
	parameter int DEPTH = mbrfb_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mbrfb_pkg::frame_desc_t push_desc,
	output logic                   full,
	input  logic                   pop,
	output mbrfb_pkg::frame_desc_t head,
	output logic                   head_valid
);
	import mbrfb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	frame_desc_t       entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/mbrfb_back.sv =====
`timescale 1ns / 1ps
module mbrfb_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mbrfb_pkg::frame_desc_t head,
	input  logic                   head_valid,
	output logic                   pop,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [7:0]             m_axis_tdata,
	output logic                   m_axis_tlast,
	output logic                   m_axis_tuser
);
	import mbrfb_pkg::*;

	logic [3:0]  idx_q;
	logic [15:0] crc_q;
	logic        tvalid_q;
	logic [7:0]  tdata_q;
	logic        tlast_q;
	logic        tuser_q;

	logic        emit;
	logic [3:0]  last_idx;
	logic        is_last;
	logic [7:0]  cur_byte;
	logic [3:0]  body_idx;
	logic        in_body;

	assign emit = head_valid && (!tvalid_q || m_axis_tready);

	always_comb begin
		if (head.unsup) begin
			last_idx = LAST_UNSUP;
		end else begin
			case (head.mode)
				MODE_TCP: last_idx = LAST_TCP;
				MODE_CRC: last_idx = LAST_CRC;
				default:  last_idx = LAST_PLAIN;
			endcase
		end
	end

	assign is_last = (idx_q == last_idx);
	assign pop = emit && is_last;

	always_comb begin
		body_idx = idx_q;
		in_body = (idx_q < IDX_BODY_END);
		cur_byte = 8'h00;
		if (head.unsup) begin
			cur_byte = 8'h00;
		end else begin
			case (head.mode)
				MODE_TCP: begin
					if (idx_q < IDX_BODY_END) begin
						cur_byte = TCP_HEADER[idx_q[2:0]];
					end else begin
						body_idx = idx_q - IDX_BODY_END;
						cur_byte = head.body[body_idx[2:0]];
					end
				end
				MODE_CRC: begin
					if (in_body) begin
						cur_byte = head.body[idx_q[2:0]];
					end else if (idx_q == IDX_BODY_END) begin
						cur_byte = crc_q[7:0];
					end else begin
						cur_byte = crc_q[15:8];
					end
				end
				default: cur_byte = head.body[idx_q[2:0]];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			tvalid_q <= 1'b0;
		end else begin
			if (emit) begin
				idx_q <= is_last ? '0 : idx_q + 1'b1;
				tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tdata_q <= cur_byte;
			tlast_q <= is_last;
			tuser_q <= head.unsup;
			if (in_body) begin
				crc_q <= crc_byte((idx_q == '0) ? CRC_INIT : crc_q, cur_byte);
			end
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata = tdata_q;
	assign m_axis_tlast = tlast_q;
	assign m_axis_tuser = tuser_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_TCP)
		else $error("byte index out of range");

	a_unsup_single: assert property (@(posedge clk) disable iff (!arst_n)
		tvalid_q && tuser_q |-> tlast_q)
		else $error("error result not marked last");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == '0)
		else $error("byte index not reset after frame end");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && tvalid_q && !m_axis_tready |=> $stable(idx_q))
		else $error("frame advanced while output stalled");

endmodule

// ===== rtl/modbus_request_frame_builder_unit.sv =====
`timescale 1ns / 1ps
// channel  | dir | tdata (low bit up)                             | tuser (low bit up)
// s_axis   | in  | unit_address[7:0] register_address[23:8]       | op[0] frame_mode[2:1]
//          |     | register_count[31:24] write_value[47:32]       | value_kind[4:3]
// m_axis   | out | frame_byte[7:0], tlast = last_byte             | unsupported[0]
//
// One byte leaves per cycle while m_axis_tready is high: 6 bytes plain, 8 with CRC trailer,
// 12 with TCP header, 1 for an unsupported write, set by the serializer; CRC is folded in per byte.
// Requests are taken into a QUEUE_DEPTH-entry queue while the previous frame streams out.
// Reset clears queue pointers and count, byte index and output valid; nothing else needs clearing.
// A stall on m_axis holds the output register; s_axis_tready drops only when the queue is full.
module modbus_request_frame_builder_unit #(
	parameter int QUEUE_DEPTH = mbrfb_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [mbrfb_pkg::IN_DATA_W-1:0] s_axis_tdata, // unit_address, register_address,
	                                                      // register_count, write_value
	input  logic [mbrfb_pkg::IN_USER_W-1:0] s_axis_tuser, // op, frame_mode, value_kind
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata, // frame_byte
	output logic                            m_axis_tlast,
	output logic                            m_axis_tuser  // unsupported
);
	import mbrfb_pkg::*;

	frame_desc_t in_desc;
	frame_desc_t head;
	logic        q_full;
	logic        head_valid;
	logic        pop;
	logic        push;

	assign s_axis_tready = !q_full;
	assign push = s_axis_tvalid && !q_full;

	mbrfb_front u_front (
		.tdata (s_axis_tdata),
		.tuser (s_axis_tuser),
		.desc  (in_desc)
	);

	mbrfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (in_desc),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	mbrfb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
